// ----- rtl/life_automaton_engine_macros.svh -----
// Assertion macros shared by the life automaton engine RTL.
`ifndef LIFE_AUTOMATON_ENGINE_MACROS_SVH
`define LIFE_AUTOMATON_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LAE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lae: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LAE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lae: next-cycle check failed");

`endif

// ----- rtl/lae_pkg.sv -----
// Types and constants of the life automaton engine.
`default_nettype none

package lae_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 6;
    localparam int SIDE_REG_W = 7;
    localparam int GEN_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CNT_W      = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GENERATIONS = 2'd2;

    // live neighbor count that gives birth, and the one that keeps a live cell
    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_COUNT  = 4'd2;

    // 3x3 neighborhood of one cell: the eight ring cells and the center
    typedef struct packed {
        logic [7:0] ring;
        logic       center;
    } t_nbr;

endpackage

`default_nettype wire

// ----- rtl/lae_cell_rule.sv -----
// Neighbor count and life rule for one cell.
`default_nettype none

module lae_cell_rule
    import lae_pkg::*;
(
    input  t_nbr i_nbr,
    output logic o_next
);

    logic [CNT_W-1:0] count;

    always_comb begin
        count = '0;
        for (int i = 0; i < 8; i++) begin
            count = count + CNT_W'(i_nbr.ring[i]);
        end
        o_next = (count == BIRTH_COUNT) || (i_nbr.center && (count == KEEP_COUNT));
    end

endmodule

`default_nettype wire

// ----- rtl/life_automaton_engine.sv -----
// Top level of the life automaton engine: toroidal board, command sequencer, row memory.
`default_nettype none
`include "life_automaton_engine_macros.svh"

// Life automaton engine. The board lives in a row-wide memory of MAX_SIDE words of
// MAX_SIDE bits; its used area is rows_in_use by cols_in_use and wraps at both edges.
// A command transaction is taken when start is high and busy is low. Write and read fetch
// the addressed row before giving the result; a run with max_generations of zero gives
// its result without reading the board. In each generation of a run the row window is
// loaded, then one shared rule unit evaluates one cell per cycle from three row registers,
// pausing at the end of each row while that row is written back through the single
// memory write port. Every command ends with exactly one result on o_cell_out,
// o_generations_run and o_stable, marked by o_done for one cycle; the receiver cannot
// stall, so grab it then. After reset a clearing pass zeroes every row of the board and
// busy stays high until it ends. Configuration is taken at any time (o_cfg_ready is
// tied high) but must only change while the engine is idle.
module life_automaton_engine
    import lae_pkg::*;
#(
    parameter int unsigned MAX_SIDE = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // command channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [COORD_W-1:0]   i_row,
    input  wire logic [COORD_W-1:0]   i_col,
    input  wire logic                 i_cell_in,
    // result channel
    output logic                      o_done,
    output logic                      o_cell_out,
    output logic [GEN_W-1:0]          o_generations_run,
    output logic                      o_stable,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GEN_W-1:0]     i_cfg_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);     // holds a side length
    localparam int IW = $clog2(MAX_SIDE);         // indexes a row or a column
    localparam int CW = (SW > SIDE_REG_W) ? SW : SIDE_REG_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CMD,
        S_LOAD,
        S_CELL,
        S_WRITE
    } t_state;

    // configuration registers
    logic [SIDE_REG_W-1:0] r_rows_in_use;
    logic [SIDE_REG_W-1:0] r_cols_in_use;
    logic [GEN_W-1:0]      r_max_gen;

    // sequencer and command registers
    t_state                r_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [COORD_W-1:0]    r_row_in;
    logic [COORD_W-1:0]    r_col_in;
    logic                  r_cell_in;
    logic [IW-1:0]         r_r;
    logic [IW-1:0]         r_c;
    logic [1:0]            r_phase;
    logic [GEN_W-1:0]      r_gen;
    logic                  r_changed;

    // row window: rows r-1, r, r+1 as they were before this generation, plus row 0
    logic [MAX_SIDE-1:0]   r_up;
    logic [MAX_SIDE-1:0]   r_mid;
    logic [MAX_SIDE-1:0]   r_dn;
    logic [MAX_SIDE-1:0]   r_first;
    logic [MAX_SIDE-1:0]   r_new;

    // result registers
    logic                  r_done;
    logic                  r_cell_out;
    logic [GEN_W-1:0]      r_gen_out;
    logic                  r_stable;

    // board memory
    logic [MAX_SIDE-1:0]   mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]   r_rdata;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [MAX_SIDE-1:0]   mem_wdata;
    logic [IW-1:0]         mem_raddr;

    logic [SW-1:0]         nr;
    logic [SW-1:0]         nc;
    logic                  in_range;
    logic [IW-1:0]         lf;
    logic [IW-1:0]         rt;
    t_nbr                  nbr;
    logic                  cell_next;
    logic [GEN_W-1:0]      n_gen;

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_done            = r_done;
    assign o_cell_out        = r_cell_out;
    assign o_generations_run = r_gen_out;
    assign o_stable          = r_stable;

    // Clamp the side registers into 1..MAX_SIDE.
    always_comb begin
        if (r_rows_in_use == '0) begin
            nr = SW'(1);
        end else if (CW'(r_rows_in_use) > CW'(MAX_SIDE)) begin
            nr = SW'(MAX_SIDE);
        end else begin
            nr = SW'(r_rows_in_use);
        end
        if (r_cols_in_use == '0) begin
            nc = SW'(1);
        end else if (CW'(r_cols_in_use) > CW'(MAX_SIDE)) begin
            nc = SW'(MAX_SIDE);
        end else begin
            nc = SW'(r_cols_in_use);
        end
    end

    assign in_range = (CW'(r_row_in) < CW'(nr)) && (CW'(r_col_in) < CW'(nc));

    // Wrapped column neighbors of the cell under evaluation.
    always_comb begin
        lf = (r_c == '0) ? IW'(nc - SW'(1)) : (r_c - IW'(1));
        rt = ((SW'(r_c) + SW'(1)) >= nc) ? '0 : (r_c + IW'(1));
    end

    always_comb begin
        nbr.ring   = {r_up[lf], r_up[r_c], r_up[rt],
                      r_mid[lf], r_mid[rt],
                      r_dn[lf], r_dn[r_c], r_dn[rt]};
        nbr.center = r_mid[r_c];
    end

    lae_cell_rule u_rule (
        .i_nbr  (nbr),
        .o_next (cell_next)
    );

    assign n_gen = r_gen + GEN_W'(1);

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_r;
        mem_wdata = r_new;
        mem_raddr = r_r;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_FETCH: begin
                mem_raddr = IW'(r_row_in);
            end
            S_CMD: begin
                // read-modify-write of one cell inside the fetched row
                mem_waddr = IW'(r_row_in);
                mem_wdata = r_rdata;
                if ((t_cmd'(r_cmd) == CMD_WRITE) && in_range) begin
                    mem_we                     = 1'b1;
                    mem_wdata[IW'(r_col_in)]   = r_cell_in;
                end
            end
            S_LOAD: begin
                case (r_phase)
                    2'd0:    mem_raddr = IW'(nr - SW'(1));
                    2'd1:    mem_raddr = '0;
                    2'd2:    mem_raddr = (nr == SW'(1)) ? '0 : IW'(1);
                    default: mem_raddr = '0;
                endcase
            end
            S_CELL: begin
                // fetch row r+2 ahead; used only where it has not wrapped
                mem_raddr = r_r + IW'(2);
            end
            S_WRITE: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= SIDE_REG_W'(64);
            r_cols_in_use <= SIDE_REG_W'(64);
            r_max_gen     <= GEN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS_IN_USE:     r_rows_in_use <= i_cfg_data[SIDE_REG_W-1:0];
                CFG_COLS_IN_USE:     r_cols_in_use <= i_cfg_data[SIDE_REG_W-1:0];
                CFG_MAX_GENERATIONS: r_max_gen     <= i_cfg_data;
                default:             r_max_gen     <= r_max_gen;
            endcase
        end
    end

    // Sequencer: state, row window and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_r     <= '0;
            r_c     <= '0;
            r_phase <= '0;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    // sweep the board to all dead, one row a cycle
                    if (r_r == IW'(MAX_SIDE - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_r <= r_r + IW'(1);
                end
                S_IDLE: begin
                    // every result arrives on the way into idle; drop the strobe here
                    r_done <= 1'b0;
                    if (start) begin
                        r_cmd     <= i_cmd;
                        r_row_in  <= i_row;
                        r_col_in  <= i_col;
                        r_cell_in <= i_cell_in;
                        r_gen     <= '0;
                        r_r       <= '0;
                        r_phase   <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_WRITE, CMD_READ: r_state <= S_FETCH;
                            CMD_RUN:  r_state <= (r_max_gen == '0) ? S_CMD : S_LOAD;
                            default:  r_state <= S_CMD;
                        endcase
                    end
                end
                S_FETCH: begin
                    // row data lands in r_rdata at this edge
                    r_state <= S_CMD;
                end
                S_CMD: begin
                    r_done     <= 1'b1;
                    r_cell_out <= (t_cmd'(r_cmd) == CMD_READ) && in_range
                                  && r_rdata[IW'(r_col_in)];
                    r_gen_out  <= '0;
                    r_stable   <= 1'b0;
                    r_state    <= S_IDLE;
                end
                S_LOAD: begin
                    // pipeline the three reads of the window
                    case (r_phase)
                        2'd1: begin
                            r_up    <= r_rdata;
                            r_phase <= 2'd2;
                        end
                        2'd2: begin
                            r_mid   <= r_rdata;
                            r_first <= r_rdata;
                            r_phase <= 2'd3;
                        end
                        2'd3: begin
                            r_dn      <= r_rdata;
                            r_new     <= r_mid;
                            r_c       <= '0;
                            r_r       <= '0;
                            r_changed <= 1'b0;
                            r_phase   <= 2'd0;
                            r_state   <= S_CELL;
                        end
                        default: r_phase <= 2'd1;
                    endcase
                end
                S_CELL: begin
                    r_new[r_c] <= cell_next;
                    if (cell_next != r_mid[r_c]) begin
                        r_changed <= 1'b1;
                    end
                    if (SW'(r_c) == (nc - SW'(1))) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_c <= r_c + IW'(1);
                    end
                end
                S_WRITE: begin
                    if (SW'(r_r) == (nr - SW'(1))) begin
                        // generation done: stop on a still board or at the limit
                        r_gen <= n_gen;
                        if (!r_changed || (n_gen == r_max_gen)) begin
                            r_done     <= 1'b1;
                            r_cell_out <= 1'b0;
                            r_gen_out  <= n_gen;
                            r_stable   <= !r_changed;
                            r_state    <= S_IDLE;
                        end else begin
                            r_r     <= '0;
                            r_phase <= '0;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        // slide the window down one row; the wrapped row comes from r_first
                        r_up  <= r_mid;
                        r_mid <= r_dn;
                        r_new <= r_dn;
                        r_dn  <= ((SW'(r_r) + SW'(2)) >= nr) ? r_first : r_rdata;
                        r_r   <= r_r + IW'(1);
                        r_c   <= '0;
                        r_state <= S_CELL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Busy is high in the cycle after a command is accepted.
    `LAE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // Results never come back to back.
    `LAE_ASSERT_NXT(a_done_single, o_done, !o_done)
    // A stable report always counts at least one generation.
    `LAE_ASSERT_IMP(a_stable_gen, o_done && o_stable, o_generations_run != '0)
    // The board is never written while idle.
    `LAE_ASSERT_IMP(a_idle_no_write, r_state == S_IDLE, !mem_we)
    // The cell column stays inside the used width.
    `LAE_ASSERT_IMP(a_col_bound, r_state == S_CELL, SW'(r_c) < nc)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the toroidal life automaton engine.
`default_nettype none

module tb_top;
    import lae_pkg::*;

    localparam int unsigned SIDE        = 64;
    // generous bound on cycles with no transaction at all, well above the
    // run budget below that caps the slowest run the stimulus allows
    localparam int          STALL_LIMIT = 100000;
    localparam int          RANDOM_ITEMS = 118;
    // cost budget for one random run, in cycles
    localparam int          RUN_BUDGET  = 16000;
    // command code the engine leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic             rd_bit;
        logic [GEN_W-1:0] gens;
        logic             stab;
    } life_result_t;

    typedef enum bit {STEP_CMD, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CMD_W-1:0]       cmd;
        logic [COORD_W-1:0]     row;
        logic [COORD_W-1:0]     col;
        logic                   cin;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [GEN_W-1:0]       reg_val;
        bit                     typed;
        life_result_t           want;
    } plan_step_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [CMD_W-1:0]       i_cmd = '0;
    logic [COORD_W-1:0]     i_row = '0;
    logic [COORD_W-1:0]     i_col = '0;
    logic                   i_cell_in = 1'b0;
    logic                   o_done;
    logic                   o_cell_out;
    logic [GEN_W-1:0]       o_generations_run;
    logic                   o_stable;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [GEN_W-1:0]       i_cfg_data = '0;

    // shadow of the engine: board, raw register values, pending results
    bit             life_board [0:SIDE-1][0:SIDE-1];
    bit             next_gen   [0:SIDE-1][0:SIDE-1];
    int unsigned    rows_reg  = 64;
    int unsigned    cols_reg  = 64;
    int unsigned    gen_limit = 1;
    life_result_t   pending_results[$];
    plan_step_t     directed_plan[$];
    bit             quiet_sender = 1'b0;
    int             fails = 0;
    int             stall_cycles = 0;

    life_automaton_engine #(
        .MAX_SIDE(SIDE)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_row              (i_row),
        .i_col              (i_col),
        .i_cell_in          (i_cell_in),
        .o_done             (o_done),
        .o_cell_out         (o_cell_out),
        .o_generations_run  (o_generations_run),
        .o_stable           (o_stable),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // A size register of zero acts as one; anything past the board acts as the board.
    function automatic int unsigned fit_side(input int unsigned v);
        if (v < 1) return 1;
        if (v > SIDE) return SIDE;
        return v;
    endfunction

    // Count live cells around (r, c) with wrap at both edges. On tiny boards the
    // same cell can sit at several neighbor positions; count it at each.
    function automatic int unsigned live_around(input int unsigned r, input int unsigned c,
                                                input int unsigned nr, input int unsigned nc);
        int unsigned up;
        int unsigned dn;
        int unsigned lf;
        int unsigned rt;
        up = (r == 0) ? nr - 1 : r - 1;
        dn = (r + 1 >= nr) ? 0 : r + 1;
        lf = (c == 0) ? nc - 1 : c - 1;
        rt = (c + 1 >= nc) ? 0 : c + 1;
        return life_board[up][lf] + life_board[up][c] + life_board[up][rt]
             + life_board[r][lf] + life_board[r][rt]
             + life_board[dn][lf] + life_board[dn][c] + life_board[dn][rt];
    endfunction

    // Apply one command to the shadow board and return the result it must produce.
    function automatic life_result_t apply_cmd(input logic [CMD_W-1:0] c,
                                               input logic [COORD_W-1:0] r,
                                               input logic [COORD_W-1:0] cl,
                                               input logic v);
        life_result_t res;
        int unsigned  nr;
        int unsigned  nc;
        int unsigned  gens;
        int unsigned  n;
        bit           changed;
        bit           settled;
        bit           nxt;
        res = '0;
        nr = fit_side(rows_reg);
        nc = fit_side(cols_reg);
        case (c)
            CMD_WRITE: begin
                if (r < nr && cl < nc) life_board[r][cl] = v;
            end
            CMD_READ: begin
                if (r < nr && cl < nc) res.rd_bit = life_board[r][cl];
            end
            CMD_RUN: begin
                gens = 0;
                changed = 1'b0;
                settled = 1'b0;
                while (gens < gen_limit && !settled) begin
                    changed = 1'b0;
                    for (int y = 0; y < nr; y++) begin
                        for (int x = 0; x < nc; x++) begin
                            n = live_around(y, x, nr, nc);
                            nxt = (n == BIRTH_COUNT) || (life_board[y][x] && n == KEEP_COUNT);
                            next_gen[y][x] = nxt;
                            if (nxt != life_board[y][x]) changed = 1'b1;
                        end
                    end
                    for (int y = 0; y < nr; y++)
                        for (int x = 0; x < nc; x++)
                            life_board[y][x] = next_gen[y][x];
                    gens = (gens + 1) & 16'hFFFF;
                    settled = !changed;
                end
                res.gens = gens[GEN_W-1:0];
                res.stab = (gens > 0) && !changed;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        return quiet_sender ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic plan_cmd(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] cl, input logic v, input bit typed,
                            input logic want_cell, input logic [GEN_W-1:0] want_gens,
                            input logic want_stab);
        plan_step_t s;
        s.kind = STEP_CMD;
        s.cmd = c;
        s.row = r;
        s.col = cl;
        s.cin = v;
        s.reg_idx = '0;
        s.reg_val = '0;
        s.typed = typed;
        s.want.rd_bit = want_cell;
        s.want.gens = want_gens;
        s.want.stab = want_stab;
        directed_plan.push_back(s);
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
        plan_step_t s;
        s.kind = STEP_CFG;
        s.cmd = '0;
        s.row = '0;
        s.col = '0;
        s.cin = 1'b0;
        s.reg_idx = idx;
        s.reg_val = val;
        s.typed = 1'b0;
        s.want = '0;
        directed_plan.push_back(s);
    endtask

    // Drop start and hold until every pending result is back, then a short pause.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Send one command transaction; the expectation is queued at acceptance.
    task automatic issue_cmd(input logic [CMD_W-1:0] c, input logic [COORD_W-1:0] r,
                             input logic [COORD_W-1:0] cl, input logic v, input bit typed,
                             input life_result_t typed_res, input int gap);
        life_result_t predicted;
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_cmd     <= c;
        i_row     <= r;
        i_col     <= cl;
        i_cell_in <= v;
        predicted = apply_cmd(c, r, cl, v);
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Write one register once the engine has gone idle.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GEN_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS_IN_USE:     rows_reg  = val & 16'h007F;
            CFG_COLS_IN_USE:     cols_reg  = val & 16'h007F;
            CFG_MAX_GENERATIONS: gen_limit = val;
            default: ;
        endcase
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        fails++;
    endtask

    // Result checker: every strobe must match the oldest pending expectation.
    always @(posedge i_clk) begin : result_check
        life_result_t want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual cell %0d gens %0d stable %0d",
                         $time, o_cell_out, o_generations_run, o_stable);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (o_cell_out !== want.rd_bit)
                    report_field("cell_out", want.rd_bit, o_cell_out);
                if (o_generations_run !== want.gens)
                    report_field("generations_run", want.gens, o_generations_run);
                if (o_stable !== want.stab)
                    report_field("stable", want.stab, o_stable);
            end
        end
    end

    // Watchdog: any command, result or register transaction restarts the count.
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1 || (i_cfg_valid && o_cfg_ready === 1'b1))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired with %0d results pending", $time,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        plan_step_t   s;
        int           made;
        int           phase_len;
        int           pick;
        int unsigned  nr;
        int unsigned  nc;
        int unsigned  cap;
        logic [GEN_W-1:0] gen_val;
        logic [GEN_W-1:0] rows_val;
        logic [GEN_W-1:0] cols_val;
        logic [CMD_W-1:0] noise_cmd;

        // Directed part. Reset leaves a 64 x 64 empty board and a limit of one generation.
        plan_cmd(CMD_READ,   0,  0,  0, 1, 0, 0, 0);
        plan_cmd(CMD_READ,   63, 63, 0, 1, 0, 0, 0);
        plan_cmd(CMD_RUN,    0,  0,  0, 1, 0, 1, 1);   // empty board settles at once
        plan_cmd(CMD_UNUSED, 63, 63, 1, 1, 0, 0, 0);   // unused command: all zero
        plan_cmd(CMD_WRITE,  63, 63, 1, 1, 0, 0, 0);
        plan_cmd(CMD_READ,   63, 63, 0, 1, 1, 0, 0);
        // four corners form a block across the wrap
        plan_cmd(CMD_WRITE,  0,  0,  1, 1, 0, 0, 0);
        plan_cmd(CMD_WRITE,  0,  63, 1, 1, 0, 0, 0);
        plan_cmd(CMD_WRITE,  63, 0,  1, 1, 0, 0, 0);
        plan_cmd(CMD_RUN,    0,  0,  0, 0, 0, 0, 0);
        // zero generation limit computes nothing
        plan_cfg(CFG_MAX_GENERATIONS, 16'd0);
        plan_cmd(CMD_RUN,    0,  0,  0, 1, 0, 0, 0);
        // zero rows acts as one: a single-cell torus
        plan_cfg(CFG_ROWS_IN_USE, 16'd0);
        plan_cfg(CFG_COLS_IN_USE, 16'd1);
        plan_cmd(CMD_READ,   0,  1,  0, 1, 0, 0, 0);   // out of range reads zero
        plan_cmd(CMD_WRITE,  1,  0,  1, 1, 0, 0, 0);   // out of range write is dropped
        plan_cfg(CFG_MAX_GENERATIONS, 16'hFFFF);
        plan_cmd(CMD_RUN,    0,  0,  0, 0, 0, 0, 0);   // lone cell sees itself eight times
        plan_cmd(CMD_READ,   0,  0,  0, 0, 0, 0, 0);
        // oversize rows clamp to the board; two columns wrap onto each other
        plan_cfg(CFG_ROWS_IN_USE, 16'd127);
        plan_cfg(CFG_COLS_IN_USE, 16'd2);
        plan_cmd(CMD_WRITE,  0,  1,  1, 1, 0, 0, 0);
        plan_cmd(CMD_WRITE,  63, 0,  0, 1, 0, 0, 0);
        plan_cmd(CMD_RUN,    0,  0,  0, 0, 0, 0, 0);
        // 2 x 2 torus
        plan_cfg(CFG_MAX_GENERATIONS, 16'd3);
        plan_cfg(CFG_ROWS_IN_USE, 16'd2);
        plan_cmd(CMD_WRITE,  1,  1,  1, 1, 0, 0, 0);
        plan_cmd(CMD_WRITE,  1,  0,  1, 1, 0, 0, 0);
        plan_cmd(CMD_RUN,    0,  0,  0, 0, 0, 0, 0);
        plan_cmd(CMD_READ,   1,  1,  0, 0, 0, 0, 0);

        // hold reset, then release it at a clock edge
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            s = directed_plan[i];
            if (s.kind == STEP_CFG)
                set_reg(s.reg_idx, s.reg_val);
            else
                issue_cmd(s.cmd, s.row, s.col, s.cin, s.typed, s.want, pick_gap());
        end

        // Random part: phases of one board shape each, mostly in-range traffic.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                6:       rows_val = 16'd0;
                7:       rows_val = GEN_W'($urandom_range(65, 127));
                8:       rows_val = 16'd64;
                9:       rows_val = GEN_W'($urandom_range(1, 64));
                default: rows_val = GEN_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                6:       cols_val = 16'd0;
                7:       cols_val = GEN_W'($urandom_range(65, 127));
                8:       cols_val = 16'd64;
                9:       cols_val = GEN_W'($urandom_range(1, 64));
                default: cols_val = GEN_W'($urandom_range(1, 8));
            endcase
            nr = fit_side(rows_val);
            nc = fit_side(cols_val);
            // keep one run inside the cycle budget
            cap = RUN_BUDGET / (4 + nr * (nc + 1));
            case ($urandom_range(0, 5))
                0:       gen_val = 16'd0;
                1:       gen_val = GEN_W'($urandom_range(1, cap));
                default: gen_val = GEN_W'($urandom_range(1, (cap < 30) ? cap : 30));
            endcase
            set_reg(CFG_ROWS_IN_USE, rows_val);
            set_reg(CFG_COLS_IN_USE, cols_val);
            set_reg(CFG_MAX_GENERATIONS, gen_val);
            quiet_sender = ($urandom_range(0, 2) == 0);
            phase_len = $urandom_range(12, 30);

            for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    issue_cmd(CMD_WRITE, COORD_W'($urandom_range(0, nr - 1)),
                              COORD_W'($urandom_range(0, nc - 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0, pick_gap());
                    made++;
                end else if (pick < 70) begin
                    issue_cmd(CMD_READ, COORD_W'($urandom_range(0, nr - 1)),
                              COORD_W'($urandom_range(0, nc - 1)),
                              1'($urandom_range(0, 1)), 1'b0, '0, pick_gap());
                    made++;
                end else if (pick < 82) begin
                    issue_cmd(CMD_RUN, COORD_W'($urandom_range(0, 63)),
                              COORD_W'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1)), 1'b0, '0, pick_gap());
                    made++;
                end else if (pick < 85) begin
                    issue_cmd(CMD_UNUSED, COORD_W'($urandom_range(0, 63)),
                              COORD_W'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1)), 1'b0, '0, pick_gap());
                    made++;
                end else if (pick < 95) begin
                    // noise: any coordinates, so most land outside the board in use
                    noise_cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
                    issue_cmd(noise_cmd, COORD_W'($urandom_range(0, 63)),
                              COORD_W'($urandom_range(0, 63)),
                              1'($urandom_range(0, 1)), 1'b0, '0, pick_gap());
                    made++;
                end else begin
                    // hold off until the engine has answered everything
                    settle();
                end
            end
        end

        settle();
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
